[design/ihex_pkg.sv]
// shared types, constants and helpers for the hex record loader
`timescale 1ns / 1ps
package ihex_pkg;

   localparam int ADDR_WIDTH = 32;
   localparam int POS_WIDTH = 10;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_WIDTH = $clog2(QUEUE_DEPTH);
   localparam int QCNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   localparam logic [POS_WIDTH-1:0] POS_MAX = {POS_WIDTH{1'b1}};

   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_START = 8'h3A;

   localparam logic [7:0] REC_DATA = 8'h00;
   localparam logic [7:0] REC_SEGMENT = 8'h02;
   localparam logic [7:0] REC_LINEAR = 8'h04;

   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_ERROR = 1'b1;

   localparam logic [31:0] LIMIT_RESET = 32'd512;

   typedef struct packed {
      logic        kind;
      logic [31:0] addr;
      logic [7:0]  data;
   } word_type;

   typedef struct packed {
      logic     valid;
      word_type word;
   } push_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] value;
   } nibble_type;

   function automatic nibble_type hex_decode(input logic [7:0] c);
      nibble_type n;
      n.ok = 1'b1;
      n.value = 4'd0;
      if (c inside {[8'h30:8'h39]}) begin
         n.value = c[3:0];
      end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
         n.value = 4'(c[2:0] + 3'd1) + 4'd8;
      end else begin
         n.ok = 1'b0;
      end
      return n;
   endfunction

endpackage

[design/ihex_if.sv]
// channel interfaces: character input, result output, register write
`timescale 1ns / 1ps

interface ihex_char_if import ihex_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [7:0] char_in;
   modport source (output valid, output char_in, input ready);
   modport sink (input valid, input char_in, output ready);
endinterface

interface ihex_rsp_if import ihex_pkg::*; ();
   logic        valid;
   logic        ready;
   logic        kind;
   logic [31:0] write_address;
   logic [7:0]  write_data;
   modport source (output valid, output kind, output write_address, output write_data,
                   input ready);
   modport sink (input valid, input kind, input write_address, input write_data,
                 output ready);
endinterface

interface ihex_csr_if import ihex_pkg::*; ();
   logic        valid;
   logic        ready;
   logic [31:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

[design/ihex_front.sv]
// front end: line parser that turns characters into write and error words
`timescale 1ns / 1ps
module ihex_front import ihex_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       char_valid,
   input  logic [7:0] char_in,
   output logic       char_ready,
   input  logic       queue_ready,
   output push_type   push
);

   logic [POS_WIDTH-1:0]  pos_ff, pos_in;
   logic [7:0]            count_ff, count_in;
   logic [15:0]           raddr_ff, raddr_in;
   logic [7:0]            rkind_ff, rkind_in;
   logic [ADDR_WIDTH-1:0] base_ff, base_in;
   logic [15:0]           acc_ff, acc_in;
   logic [7:0]            index_ff, index_in;
   logic                  failed_ff, failed_in;

   nibble_type            nib;
   logic                  fire;
   logic                  in_field;
   logic                  is_data;
   logic                  is_base;
   logic [15:0]           acc_new;
   logic [POS_WIDTH-1:0]  data_end;
   logic [ADDR_WIDTH-1:0] byte_addr;
   logic [47:0]           base_wide;

   assign char_ready = queue_ready;
   assign fire = char_valid & char_ready;
   assign nib = hex_decode(char_in);
   assign acc_new = {acc_ff[11:0], nib.value};
   assign data_end = {1'b0, count_ff, 1'b0} + POS_WIDTH'(9);
   assign byte_addr = base_ff + ADDR_WIDTH'(raddr_ff) + ADDR_WIDTH'(index_ff);
   assign base_wide = (rkind_ff == REC_SEGMENT) ? {32'd0, acc_new} << 4
                                                : {32'd0, acc_new} << 16;

   always_comb begin
      in_field = 1'b0;
      is_data = 1'b0;
      is_base = 1'b0;
      if (pos_ff <= POS_WIDTH'(8)) begin
         in_field = 1'b1;
      end else if (rkind_ff == REC_DATA && pos_ff < data_end) begin
         in_field = 1'b1;
         is_data = 1'b1;
      end else if ((rkind_ff == REC_SEGMENT || rkind_ff == REC_LINEAR) &&
                   pos_ff <= POS_WIDTH'(12)) begin
         in_field = 1'b1;
         is_base = 1'b1;
      end
   end

   always_comb begin
      pos_in = pos_ff;
      count_in = count_ff;
      raddr_in = raddr_ff;
      rkind_in = rkind_ff;
      base_in = base_ff;
      acc_in = acc_ff;
      index_in = index_ff;
      failed_in = failed_ff;
      push = '0;
      if (fire && !failed_ff) begin
         if (char_in == CHAR_NEWLINE) begin
            if (pos_ff == '0) begin
               failed_in = 1'b1;
               push.valid = 1'b1;
               push.word.kind = KIND_ERROR;
            end else begin
               pos_in = '0;
            end
         end else if (pos_ff == '0) begin
            if (char_in != CHAR_START) begin
               failed_in = 1'b1;
               push.valid = 1'b1;
               push.word.kind = KIND_ERROR;
            end else begin
               acc_in = '0;
               pos_in = POS_WIDTH'(1);
            end
         end else if (in_field && !nib.ok) begin
            failed_in = 1'b1;
            push.valid = 1'b1;
            push.word.kind = KIND_ERROR;
         end else begin
            if (in_field) begin
               acc_in = acc_new;
               if (pos_ff == POS_WIDTH'(2)) begin
                  count_in = acc_new[7:0];
                  acc_in = '0;
               end else if (pos_ff == POS_WIDTH'(6)) begin
                  raddr_in = acc_new;
                  acc_in = '0;
               end else if (pos_ff == POS_WIDTH'(8)) begin
                  rkind_in = acc_new[7:0];
                  acc_in = '0;
                  index_in = '0;
               end else if (is_data && !pos_ff[0]) begin
                  push.valid = 1'b1;
                  push.word.kind = KIND_WRITE;
                  push.word.addr = 32'(byte_addr);
                  push.word.data = acc_new[7:0];
                  acc_in = '0;
                  index_in = index_ff + 8'd1;
               end else if (is_base && pos_ff == POS_WIDTH'(12)) begin
                  base_in = base_wide[ADDR_WIDTH-1:0];
                  acc_in = '0;
               end
            end
            if (pos_ff != POS_MAX) begin
               pos_in = pos_ff + POS_WIDTH'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         count_ff <= '0;
         raddr_ff <= '0;
         rkind_ff <= '0;
         base_ff <= '0;
         acc_ff <= '0;
         index_ff <= '0;
         failed_ff <= 1'b0;
      end else begin
         pos_ff <= pos_in;
         count_ff <= count_in;
         raddr_ff <= raddr_in;
         rkind_ff <= rkind_in;
         base_ff <= base_in;
         acc_ff <= acc_in;
         index_ff <= index_in;
         failed_ff <= failed_in;
      end
   end

   a_failed_sticks: assert property (@(posedge clock) disable iff (reset)
      failed_ff |=> failed_ff) else $error("failed flag cleared");
   a_silent_after_fail: assert property (@(posedge clock) disable iff (reset)
      failed_ff |-> !push.valid) else $error("word pushed after failure");
   a_error_sets_fail: assert property (@(posedge clock) disable iff (reset)
      (push.valid && push.word.kind == KIND_ERROR) |=> failed_ff)
      else $error("error word without failure");

endmodule

[design/ihex_queue.sv]
// short word queue between the parser and the write stage
`timescale 1ns / 1ps
module ihex_queue import ihex_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  push_type push,
   output logic     push_ready,
   output logic     pop_valid,
   output word_type pop_word,
   input  logic     pop
);

   word_type              mem [QUEUE_DEPTH];
   logic [QPTR_WIDTH-1:0] wptr_ff, wptr_in;
   logic [QPTR_WIDTH-1:0] rptr_ff, rptr_in;
   logic [QCNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic                  do_push;
   logic                  do_pop;

   assign push_ready = (cnt_ff != QCNT_WIDTH'(QUEUE_DEPTH));
   assign pop_valid = (cnt_ff != '0);
   assign pop_word = mem[rptr_ff];
   assign do_push = push.valid & push_ready;
   assign do_pop = pop & pop_valid;

   always_comb begin
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wptr_in = (wptr_ff == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
      end
      if (do_pop) begin
         rptr_in = (rptr_ff == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wptr_ff] <= push.word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff <= cnt_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= QCNT_WIDTH'(QUEUE_DEPTH)) else $error("queue count overflow");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> push_ready) else $error("word pushed into full queue");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> pop_valid) else $error("word popped from empty queue");

endmodule

[design/ihex_back.sv]
// back end: limit check, limit register and result output register
`timescale 1ns / 1ps
module ihex_back import ihex_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        pop_valid,
   input  word_type    pop_word,
   output logic        pop,
   input  logic        csr_valid,
   input  logic [31:0] csr_data,
   output logic        csr_ready,
   output logic        rsp_valid,
   output logic        rsp_kind,
   output logic [31:0] rsp_address,
   output logic [7:0]  rsp_data,
   input  logic        rsp_ready
);

   logic [31:0] limit_ff, limit_in;
   logic        valid_ff, valid_in;
   word_type    out_ff, out_in;
   logic        pass;

   assign csr_ready = 1'b1;
   assign pop = pop_valid & (~valid_ff | rsp_ready);
   assign pass = (pop_word.kind == KIND_ERROR) | (pop_word.addr < limit_ff);

   always_comb begin
      limit_in = limit_ff;
      valid_in = valid_ff;
      out_in = out_ff;
      if (csr_valid) begin
         limit_in = csr_data;
      end
      if (pop) begin
         valid_in = pass;
         out_in = pop_word;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
         valid_ff <= 1'b0;
      end else begin
         limit_ff <= limit_in;
         valid_ff <= valid_in;
      end
      out_ff <= out_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_kind = out_ff.kind;
   assign rsp_address = out_ff.addr;
   assign rsp_data = out_ff.data;

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && out_ff.kind == KIND_ERROR) |-> (out_ff.addr == '0 && out_ff.data == '0))
      else $error("error result with nonzero payload");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !rsp_ready) |=> (valid_ff && $stable(out_ff)))
      else $error("result changed while stalled");
   a_drop_silent: assert property (@(posedge clock) disable iff (reset)
      (pop && !pass) |=> !valid_ff) else $error("dropped write shown on rsp");

endmodule

[design/intel_hex_record_loader.sv]
// top level: intel hex record loader, one character per word
// a character that yields a write or error is held in the queue, then in the output register, before it shows on rsp
// throughput: one character per cycle while the queue has room; rsp stalls back up through a 2-word queue
// writes at or above memory_limit are dropped in the back end and give no result
// reset: synchronous, clears parser state, base, failure flag; memory_limit to 512
`timescale 1ns / 1ps
module intel_hex_record_loader import ihex_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   ihex_char_if.sink    req,
   ihex_rsp_if.source   rsp,
   ihex_csr_if.sink     csr
);

   push_type push;
   logic     queue_ready;
   logic     pop_valid;
   word_type pop_word;
   logic     pop;

   ihex_front u_front (
      .clock       (clock),
      .reset       (reset),
      .char_valid  (req.valid),
      .char_in     (req.char_in),
      .char_ready  (req.ready),
      .queue_ready (queue_ready),
      .push        (push)
   );

   ihex_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_ready (queue_ready),
      .pop_valid  (pop_valid),
      .pop_word   (pop_word),
      .pop        (pop)
   );

   ihex_back u_back (
      .clock       (clock),
      .reset       (reset),
      .pop_valid   (pop_valid),
      .pop_word    (pop_word),
      .pop         (pop),
      .csr_valid   (csr.valid),
      .csr_data    (csr.data),
      .csr_ready   (csr.ready),
      .rsp_valid   (rsp.valid),
      .rsp_kind    (rsp.kind),
      .rsp_address (rsp.write_address),
      .rsp_data    (rsp.write_data),
      .rsp_ready   (rsp.ready)
   );

endmodule

[tb/intel_hex_record_loader_tb.sv]
// self-checking testbench for the intel hex record loader: directed table, then random records
`timescale 1ns / 1ps
module intel_hex_record_loader_tb;
   import ihex_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int SETTLE = 4;
   localparam int LONG_HOLD = 300;
   localparam int PHASE_CHARS = 60;
   localparam int LONG_JUNK = 40;
   localparam logic [7:0] CHAR_CR = 8'h0D;

   typedef enum int {
      FAULT_START, FAULT_EMPTY, FAULT_HEADER, FAULT_DATA, FAULT_BASE, FAULT_CR
   } fault_kind_type;

   typedef struct packed {
      logic [7:0] c;
      logic       typed;
      word_type   w;
   } stim_row_type;

   // a data record crossing the reset limit, then an end of file record
   localparam stim_row_type DIRECTED [27] = '{
      '{CHAR_START, 1'b0, '0}, '{"0", 1'b0, '0}, '{"3", 1'b0, '0},
      '{"0", 1'b0, '0}, '{"1", 1'b0, '0}, '{"F", 1'b0, '0}, '{"E", 1'b0, '0},
      '{"0", 1'b0, '0}, '{"0", 1'b0, '0},
      '{"0", 1'b0, '0}, '{"0", 1'b1, '{KIND_WRITE, 32'h0000_01FE, 8'h00}},
      '{"f", 1'b0, '0}, '{"f", 1'b1, '{KIND_WRITE, 32'h0000_01FF, 8'hFF}},
      '{"7", 1'b0, '0}, '{"e", 1'b0, '0},
      '{CHAR_NEWLINE, 1'b0, '0},
      '{CHAR_START, 1'b0, '0}, '{"0", 1'b0, '0}, '{"0", 1'b0, '0},
      '{"0", 1'b0, '0}, '{"0", 1'b0, '0}, '{"0", 1'b0, '0}, '{"0", 1'b0, '0},
      '{"0", 1'b0, '0}, '{"1", 1'b0, '0},
      '{CHAR_CR, 1'b0, '0}, '{CHAR_NEWLINE, 1'b0, '0}
   };

   logic clock;
   logic reset;

   ihex_char_if req_if ();
   ihex_rsp_if  rsp_if ();
   ihex_csr_if  csr_if ();

   intel_hex_record_loader dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if),
      .csr   (csr_if)
   );

   // parser state mirror
   logic [9:0]  line_pos = '0;
   logic [7:0]  rec_count = '0;
   logic [15:0] rec_addr = '0;
   logic [7:0]  rec_type = '0;
   logic [31:0] base = '0;
   logic [15:0] acc = '0;
   logic [7:0]  byte_idx = '0;
   bit          stopped = 1'b0;
   logic [31:0] mem_limit = LIMIT_RESET;

   word_type       words_due [$];
   logic [7:0]     line_buf [$];
   int             chars_sent = 0;
   int             words_checked = 0;
   int             bad_words = 0;
   int             limits_used = 0;
   int             tick_total = 0;
   bit             calm = 1'b0;
   bit             hold_phase = 1'b0;
   fault_kind_type fault = FAULT_START;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic bit hex_digit(input logic [7:0] c, output logic [3:0] v);
      v = 4'd0;
      if (c >= "0" && c <= "9") v = 4'(c - "0");
      else if (c >= "a" && c <= "f") v = 4'(c - "a" + 8'd10);
      else if (c >= "A" && c <= "F") v = 4'(c - "A" + 8'd10);
      else return 1'b0;
      return 1'b1;
   endfunction

   function automatic void flag_fault(output word_type w);
      stopped = 1'b1;
      w.kind = KIND_ERROR;
      w.addr = '0;
      w.data = '0;
   endfunction

   function automatic bit parse_char(input logic [7:0] c, output word_type w);
      logic [9:0]  pos;
      logic [3:0]  nib;
      logic [31:0] addr;
      bit          in_field, is_data, is_base, got;
      w = '0;
      pos = line_pos;
      in_field = 1'b0;
      is_data = 1'b0;
      is_base = 1'b0;
      got = 1'b0;
      if (stopped) return 1'b0;
      if (c == CHAR_NEWLINE) begin
         if (pos == 0) begin
            flag_fault(w);
            return 1'b1;
         end
         line_pos = '0;
         return 1'b0;
      end
      if (pos == 0) begin
         if (c != CHAR_START) begin
            flag_fault(w);
            return 1'b1;
         end
         acc = '0;
         line_pos = 10'd1;
         return 1'b0;
      end
      if (pos <= 10'd8) begin
         in_field = 1'b1;
      end else if (rec_type == REC_DATA && int'(pos) < 9 + 2 * int'(rec_count)) begin
         in_field = 1'b1;
         is_data = 1'b1;
      end else if ((rec_type == REC_SEGMENT || rec_type == REC_LINEAR) && pos <= 10'd12) begin
         in_field = 1'b1;
         is_base = 1'b1;
      end
      if (in_field) begin
         if (!hex_digit(c, nib)) begin
            flag_fault(w);
            return 1'b1;
         end
         acc = {acc[11:0], nib};
         if (pos == 10'd2) begin
            rec_count = acc[7:0];
            acc = '0;
         end else if (pos == 10'd6) begin
            rec_addr = acc;
            acc = '0;
         end else if (pos == 10'd8) begin
            rec_type = acc[7:0];
            acc = '0;
            byte_idx = '0;
         end else if (is_data && !pos[0]) begin
            addr = base + 32'(rec_addr) + 32'(byte_idx);
            if (addr < mem_limit) begin
               w.kind = KIND_WRITE;
               w.addr = addr;
               w.data = acc[7:0];
               got = 1'b1;
            end
            acc = '0;
            byte_idx = byte_idx + 8'd1;
         end else if (is_base && pos == 10'd12) begin
            base = (rec_type == REC_SEGMENT) ? {12'h000, acc, 4'h0} : {acc, 16'h0000};
            acc = '0;
         end
      end
      if (pos != POS_MAX) line_pos = pos + 10'd1;
      return got;
   endfunction

   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 30);
   endfunction

   function automatic int junk_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 95) return $urandom_range(1, 4);
      return $urandom_range(5, 20);
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] v);
      if (v < 4'd10) return 8'h30 + 8'(v);
      return (($urandom_range(0, 1) != 0) ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
   endfunction

   function automatic logic [7:0] junk_char();
      logic [7:0] c;
      do c = 8'($urandom); while (c == CHAR_NEWLINE);
      return c;
   endfunction

   function automatic logic [7:0] nonhex_char();
      logic [7:0] c;
      logic [3:0] v;
      do c = 8'($urandom); while (c == CHAR_NEWLINE || hex_digit(c, v));
      return c;
   endfunction

   function automatic void note_mismatch(input string what, input word_type want,
                                         input word_type got);
      bad_words++;
      if (bad_words <= 10)
         $display("%s: expected kind %0d addr %h data %h, got kind %0d addr %h data %h",
                  what, want.kind, want.addr, want.data, got.kind, got.addr, got.data);
   endfunction

   function automatic void check_word();
      word_type got, want;
      got.kind = rsp_if.kind;
      got.addr = rsp_if.write_address;
      got.data = rsp_if.write_data;
      words_checked++;
      if (words_due.size() == 0) begin
         note_mismatch("word with nothing due", '0, got);
      end else begin
         want = words_due.pop_front();
         if (got.kind !== want.kind || got.addr !== want.addr || got.data !== want.data)
            note_mismatch("word mismatch", want, got);
      end
   endfunction

   task automatic add_char(input logic [7:0] c);
      line_buf = {line_buf, c};
   endtask

   task automatic push_hex(input logic [31:0] v, input int digits);
      int i;
      for (i = digits - 1; i >= 0; i--) add_char(hex_char(v[4*i +: 4]));
   endtask

   task automatic push_header(input logic [7:0] cnt, input logic [15:0] addr,
                              input logic [7:0] rtype);
      add_char(CHAR_START);
      push_hex(32'(cnt), 2);
      push_hex(32'(addr), 4);
      push_hex(32'(rtype), 2);
   endtask

   task automatic make_record(input logic [7:0] rtype, input logic [7:0] cnt,
                              input logic [15:0] addr, input logic [15:0] value,
                              input int junk);
      push_header(cnt, addr, rtype);
      if (rtype == REC_DATA) repeat (cnt) push_hex($urandom, 2);
      else if (rtype == REC_SEGMENT || rtype == REC_LINEAR) push_hex(32'(value), 4);
      else repeat ($urandom_range(0, 4)) push_hex($urandom, 2);
      push_hex($urandom, 2);
      if ($urandom_range(0, 3) == 0) add_char(CHAR_CR);
      repeat (junk) add_char(junk_char());
      add_char(CHAR_NEWLINE);
   endtask

   task automatic send_char(input logic [7:0] c, input bit typed = 1'b0,
                            input word_type typed_word = '0);
      word_type w;
      int gap;
      req_if.valid <= 1'b1;
      req_if.char_in <= c;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      if (parse_char(c, w) && !typed) words_due = {words_due, w};
      if (typed) words_due = {words_due, typed_word};
      chars_sent++;
      gap = calm ? 0 : idle_len();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_line();
      int i;
      for (i = 0; i < line_buf.size(); i++) send_char(line_buf[i]);
      line_buf.delete();
   endtask

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (words_due.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_limit(input logic [31:0] v);
      wait_drained();
      csr_if.valid <= 1'b1;
      csr_if.data <= v;
      do @(posedge clock); while (csr_if.ready !== 1'b1);
      mem_limit = v;
      limits_used++;
      csr_if.valid <= 1'b0;
   endtask

   task automatic random_line();
      int r, cut;
      logic [15:0] addr, value;
      logic [7:0] cnt, rtype;
      r = $urandom_range(0, 99);
      addr = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 600));
      cnt = ($urandom_range(0, 24) == 0) ? 8'($urandom_range(17, 255))
                                          : 8'($urandom_range(0, 16));
      if (r < 60) begin
         make_record(REC_DATA, cnt, addr, 16'h0, junk_len());
      end else if (r < 73) begin
         value = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 40)) : 16'($urandom);
         make_record(REC_SEGMENT, 8'd2, addr, value, junk_len());
      end else if (r < 86) begin
         value = ($urandom_range(0, 2) != 0) ? 16'h0 : 16'($urandom);
         make_record(REC_LINEAR, 8'd2, addr, value, junk_len());
      end else begin
         do rtype = 8'($urandom);
         while (rtype == REC_DATA || rtype == REC_SEGMENT || rtype == REC_LINEAR);
         make_record(rtype, cnt, addr, 16'($urandom), junk_len());
      end
      // cut the line short
      if ($urandom_range(0, 9) == 0) begin
         cut = $urandom_range(1, line_buf.size() - 2);
         line_buf = line_buf[0:cut-1];
         add_char(CHAR_NEWLINE);
      end
      send_line();
   endtask

   task automatic run_phase(input int budget);
      int start;
      start = chars_sent;
      while (chars_sent - start < budget) begin
         calm = ($urandom_range(0, 4) == 0);
         random_line();
      end
      calm = 1'b0;
   endtask

   task automatic end_with_fault();
      logic [7:0] c, cnt;
      fault = fault_kind_type'($urandom_range(0, 5));
      case (fault)
         FAULT_START: begin
            do c = junk_char(); while (c == CHAR_START);
            add_char(c);
         end
         FAULT_EMPTY: add_char(CHAR_NEWLINE);
         FAULT_HEADER, FAULT_CR: begin
            add_char(CHAR_START);
            repeat ($urandom_range(0, 7)) add_char(hex_char(4'($urandom)));
            add_char((fault == FAULT_CR) ? CHAR_CR : nonhex_char());
         end
         FAULT_DATA: begin
            cnt = 8'($urandom_range(1, 16));
            push_header(cnt, 16'($urandom_range(0, 400)), REC_DATA);
            repeat ($urandom_range(0, 2 * cnt - 1))
               add_char(hex_char(4'($urandom)));
            add_char(nonhex_char());
         end
         default: begin
            push_header(8'd2, 16'h0, ($urandom_range(0, 1) != 0) ? REC_SEGMENT : REC_LINEAR);
            repeat ($urandom_range(0, 3)) add_char(hex_char(4'($urandom)));
            add_char(nonhex_char());
         end
      endcase
      // parser is stopped from here on
      repeat (40) begin
         case ($urandom_range(0, 3))
            0: add_char(CHAR_START);
            1: add_char(CHAR_NEWLINE);
            default: add_char(junk_char());
         endcase
      end
      send_line();
   endtask

   initial begin : sink_side
      int hold_left, sink_gap;
      bit hold_armed;
      rsp_if.ready <= 1'b0;
      hold_left = 0;
      sink_gap = 0;
      hold_armed = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) check_word();
         if (hold_phase && !hold_armed) begin
            hold_left = LONG_HOLD;
         end
         hold_armed = hold_phase;
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (sink_gap > 0) begin
            sink_gap--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
            sink_gap = calm ? 0 : idle_len();
         end
      end
   end

   initial begin
      while (tick_total < CYCLE_LIMIT) begin
         @(posedge clock);
         tick_total++;
      end
      $display("timeout after %0d cycles, %0d words still due", tick_total, words_due.size());
      $display("intel_hex_record_loader_tb NOT OK");
      $finish;
   end

   initial begin
      reset <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.char_in <= 8'h00;
      csr_if.valid <= 1'b0;
      csr_if.data <= 32'h0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (DIRECTED[i]) send_char(DIRECTED[i].c, DIRECTED[i].typed, DIRECTED[i].w);
      run_phase(PHASE_CHARS);

      // full range, wrap past the top of the address space, long output stall
      write_limit(32'hFFFF_FFFF);
      make_record(REC_LINEAR, 8'd2, 16'h0, 16'hFFFF, 0);
      make_record(REC_DATA, 8'd4, 16'hFFFE, 16'h0, 0);
      send_line();
      hold_phase = 1'b1;
      run_phase(PHASE_CHARS);
      hold_phase = 1'b0;

      write_limit(32'd0);
      run_phase(PHASE_CHARS / 2);

      write_limit(32'($urandom_range(1, 70000)));
      make_record(REC_DATA, 8'd2, 16'($urandom_range(0, 600)), 16'h0, LONG_JUNK);
      send_line();
      run_phase(PHASE_CHARS);

      write_limit(32'd1);
      run_phase(PHASE_CHARS / 2);

      write_limit(32'd4096);
      run_phase(PHASE_CHARS / 2);
      wait_drained();
      run_phase(PHASE_CHARS / 2);

      end_with_fault();
      wait_drained();

      $display("sent %0d characters under %0d limit settings, checked %0d result words",
               chars_sent, limits_used + 1, words_checked);
      $display("run ended on %s, %0d mismatches", fault.name(), bad_words);
      if (bad_words == 0 && words_due.size() == 0) begin
         $display("intel_hex_record_loader_tb OK");
      end else begin
         $display("intel_hex_record_loader_tb NOT OK");
      end
      $finish;
   end

endmodule
